/* src/complex_integer_alu_unit_assert.svh */
// Assertion macros for the complex integer ALU.
`ifndef COMPLEX_INTEGER_ALU_UNIT_ASSERT_SVH
`define COMPLEX_INTEGER_ALU_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CIA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CIA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/cia_pkg.sv */
// Package: widths, opcodes and stage types of the complex integer ALU.
`default_nettype none

package cia_pkg;

    localparam int OPERAND_BITS = 16;
    localparam int RES_BITS     = 33;
    localparam int PROD_BITS    = 2 * OPERAND_BITS;
    localparam int SUM_BITS     = 2 * OPERAND_BITS + 2;
    localparam int NUM_BITS     = 2 * OPERAND_BITS + 1;
    localparam int DEN_BITS     = 2 * OPERAND_BITS;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef struct packed {
        logic                valid;
        logic                is_div;
        logic                dz;
        logic                neg_r;
        logic                neg_i;
        logic [NUM_BITS-1:0] n_r;
        logic [NUM_BITS-1:0] n_i;
        logic [DEN_BITS-1:0] rem_r;
        logic [DEN_BITS-1:0] rem_i;
        logic [DEN_BITS-1:0] den;
        logic [RES_BITS-1:0] pass_re;
        logic [RES_BITS-1:0] pass_im;
    } div_stage_t;

endpackage

`default_nettype wire

/* src/complex_integer_alu_unit.sv */
// Complex integer ALU: pipelined add, subtract, multiply and truncating divide.
`default_nettype none

// One item enters per cycle unless the pipeline is stalled, and passes
// through one multiply stage, one sum stage, one restoring divider stage
// per quotient bit, and an output stage with sign correction.
// Every operation runs the full pipeline depth. A downstream stall freezes
// the whole pipeline and is passed back as req_stall. Divide by zero gives
// zero parts with div_zero set.
`include "complex_integer_alu_unit_assert.svh"

module complex_integer_alu_unit
    import cia_pkg::*;
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           req_valid,
    output logic                                req_stall,
    input  wire logic [1:0]                     op,
    input  wire logic signed [OPERAND_BITS-1:0] a_re,
    input  wire logic signed [OPERAND_BITS-1:0] a_im,
    input  wire logic signed [OPERAND_BITS-1:0] b_re,
    input  wire logic signed [OPERAND_BITS-1:0] b_im,
    output logic                                rsp_valid,
    input  wire logic                           rsp_stall,
    output logic signed [RES_BITS-1:0]          res_re,
    output logic signed [RES_BITS-1:0]          res_im,
    output logic                                div_zero
);

    logic en;

    // multiply stage
    logic                        m_valid_reg;
    op_t                         m_op_reg;
    logic signed [PROD_BITS-1:0] m_rr_reg, m_ii_reg, m_ri_reg, m_ir_reg;
    logic signed [PROD_BITS-1:0] m_sqr_reg, m_sqi_reg;
    logic signed [SUM_BITS-1:0]  m_as_re_reg, m_as_im_reg;

    div_stage_t d_reg [0:NUM_BITS];
    div_stage_t d_next [0:NUM_BITS-1];
    div_stage_t s_next;

    logic                rsp_valid_reg;
    logic [RES_BITS-1:0] res_re_reg, res_im_reg;
    logic                div_zero_reg;

    assign en        = !(rsp_valid_reg && rsp_stall);
    assign req_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= req_valid;
            m_op_reg    <= op_t'(op);
            m_rr_reg    <= PROD_BITS'(a_re) * PROD_BITS'(b_re);
            m_ii_reg    <= PROD_BITS'(a_im) * PROD_BITS'(b_im);
            m_ri_reg    <= PROD_BITS'(a_re) * PROD_BITS'(b_im);
            m_ir_reg    <= PROD_BITS'(a_im) * PROD_BITS'(b_re);
            m_sqr_reg   <= PROD_BITS'(b_re) * PROD_BITS'(b_re);
            m_sqi_reg   <= PROD_BITS'(b_im) * PROD_BITS'(b_im);
            if (op_t'(op) == OP_SUB)
            begin
                m_as_re_reg <= SUM_BITS'(a_re) - SUM_BITS'(b_re);
                m_as_im_reg <= SUM_BITS'(a_im) - SUM_BITS'(b_im);
            end
            else
            begin
                m_as_re_reg <= SUM_BITS'(a_re) + SUM_BITS'(b_re);
                m_as_im_reg <= SUM_BITS'(a_im) + SUM_BITS'(b_im);
            end
        end
    end

    // sum stage: numerators, denominator, multiply result
    always_comb
    begin
        logic signed [SUM_BITS-1:0] nr;
        logic signed [SUM_BITS-1:0] ni;
        logic signed [SUM_BITS-1:0] mr;
        logic signed [SUM_BITS-1:0] mi;
        nr = SUM_BITS'(m_rr_reg) + SUM_BITS'(m_ii_reg);
        ni = SUM_BITS'(m_ir_reg) - SUM_BITS'(m_ri_reg);
        mr = SUM_BITS'(m_rr_reg) - SUM_BITS'(m_ii_reg);
        mi = SUM_BITS'(m_ri_reg) + SUM_BITS'(m_ir_reg);
        s_next.valid  = m_valid_reg;
        s_next.is_div = (m_op_reg == OP_DIV);
        s_next.den    = DEN_BITS'(m_sqr_reg) + DEN_BITS'(m_sqi_reg);
        s_next.dz     = s_next.is_div && (s_next.den == '0);
        s_next.neg_r  = nr[SUM_BITS-1];
        s_next.neg_i  = ni[SUM_BITS-1];
        s_next.n_r    = nr[SUM_BITS-1] ? NUM_BITS'(-nr) : NUM_BITS'(nr);
        s_next.n_i    = ni[SUM_BITS-1] ? NUM_BITS'(-ni) : NUM_BITS'(ni);
        s_next.rem_r  = '0;
        s_next.rem_i  = '0;
        if (m_op_reg == OP_MUL)
        begin
            s_next.pass_re = RES_BITS'(mr);
            s_next.pass_im = RES_BITS'(mi);
        end
        else
        begin
            s_next.pass_re = RES_BITS'(m_as_re_reg);
            s_next.pass_im = RES_BITS'(m_as_im_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_reg[0].valid <= 1'b0;
        end
        else if (en)
        begin
            d_reg[0] <= s_next;
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar k = 0; k < NUM_BITS; k++)
    begin : g_div
        always_comb
        begin
            logic [DEN_BITS:0] tr;
            logic [DEN_BITS:0] ti;
            tr = {d_reg[k].rem_r, d_reg[k].n_r[NUM_BITS-1]};
            ti = {d_reg[k].rem_i, d_reg[k].n_i[NUM_BITS-1]};
            d_next[k] = d_reg[k];
            if (tr >= {1'b0, d_reg[k].den})
            begin
                d_next[k].rem_r = DEN_BITS'(tr - {1'b0, d_reg[k].den});
                d_next[k].n_r   = {d_reg[k].n_r[NUM_BITS-2:0], 1'b1};
            end
            else
            begin
                d_next[k].rem_r = tr[DEN_BITS-1:0];
                d_next[k].n_r   = {d_reg[k].n_r[NUM_BITS-2:0], 1'b0};
            end
            if (ti >= {1'b0, d_reg[k].den})
            begin
                d_next[k].rem_i = DEN_BITS'(ti - {1'b0, d_reg[k].den});
                d_next[k].n_i   = {d_reg[k].n_i[NUM_BITS-2:0], 1'b1};
            end
            else
            begin
                d_next[k].rem_i = ti[DEN_BITS-1:0];
                d_next[k].n_i   = {d_reg[k].n_i[NUM_BITS-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                d_reg[k+1].valid <= 1'b0;
            end
            else if (en)
            begin
                d_reg[k+1] <= d_next[k];
            end
        end
    end

    // output stage: sign correction and op select
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            rsp_valid_reg <= d_reg[NUM_BITS].valid;
            div_zero_reg  <= d_reg[NUM_BITS].dz;
            if (d_reg[NUM_BITS].dz)
            begin
                res_re_reg <= '0;
                res_im_reg <= '0;
            end
            else if (d_reg[NUM_BITS].is_div)
            begin
                res_re_reg <= d_reg[NUM_BITS].neg_r ? RES_BITS'(-d_reg[NUM_BITS].n_r)
                                                    : RES_BITS'(d_reg[NUM_BITS].n_r);
                res_im_reg <= d_reg[NUM_BITS].neg_i ? RES_BITS'(-d_reg[NUM_BITS].n_i)
                                                    : RES_BITS'(d_reg[NUM_BITS].n_i);
            end
            else
            begin
                res_re_reg <= d_reg[NUM_BITS].pass_re;
                res_im_reg <= d_reg[NUM_BITS].pass_im;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign res_re    = res_re_reg;
    assign res_im    = res_im_reg;
    assign div_zero  = div_zero_reg;

    `CIA_ASSERT_IMP(a_dz_zero, rsp_valid && div_zero, res_re == '0 && res_im == '0, "div_zero result not zero")
    `CIA_ASSERT_IMP(a_dz_div, d_reg[0].valid && d_reg[0].dz, d_reg[0].is_div, "div_zero flag on non-divide item")
    `CIA_ASSERT_NEXT(a_pipe_adv, en && d_reg[NUM_BITS].valid, rsp_valid, "item lost at output stage")

endmodule

`default_nettype wire
